FILE: rtl/core/htcb_pkg.sv
`timescale 1ns / 1ps
package htcb_pkg;

	// Default sizing of the top level
	localparam int MAX_SYMBOLS_DEF = 64;
	localparam int WEIGHT_BITS_DEF = 24;

	// Fixed field widths
	localparam int SYM_W   = 6;
	localparam int WIN_W   = 24;
	localparam int LEN_W   = 6;
	localparam int CODE_W  = 63;
	localparam int CFG_W   = 7;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Longest code walk in links
	localparam int WALK_MAX = 63;

	// Request opcodes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [SYM_W-1:0] symbol;
		logic [WIN_W-1:0] weight;
		logic             last;
	} req_item_t;

	typedef struct packed {
		logic              ready_res;
		logic [LEN_W-1:0]  code_length;
		logic [LEN_W-1:0]  zero_count;
		logic [CODE_W-1:0] code_bits;
	} rsp_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_PREP_A,
		ST_SCAN_A,
		ST_TAKE_A,
		ST_PREP_B,
		ST_SCAN_B,
		ST_TAKE_B,
		ST_LINK_A,
		ST_LINK_B,
		ST_WALK,
		ST_RESULT
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_wr;
		logic build_start;
		logic init_wr;
		logic pair_start;
		logic scan_clr;
		logic scan;
		logic take_a;
		logic take_b;
		logic link_a;
		logic link_b;
		logic tree_set;
		logic query_start;
		logic walk_step;
		logic res_load;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic query_ok;
		logic init_last;
		logic scan_done;
		logic final_pair;
		logic walk_more;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/core/huffman_tree_code_builder_core.sv
`timescale 1ns / 1ps
// Huffman code builder with per-symbol code lookup.
// Request channel (req_valid/req_stall/req_data): a load transaction writes one
// symbol weight (symbols outside the alphabet are ignored); a load with last set
// then builds the tree. A query transaction names a symbol and returns one
// transaction on the response channel (rsp_valid/rsp_stall/rsp_data) with ready
// flag, code length, zero count and code bits; loads return nothing.
// Build: the live list is seeded with the n leaves, then n-1 merges follow. Each
// merge runs two linear scans of the live list for the lightest node, each
// through the chained list and weight memory reads, plus the prep, take and
// link control states.
// Query: the walk adds one code bit per link of the parent memory;
// the result sits in an output register and the next request is taken while
// it waits. req_stall is high during a build, a walk, or while a finished
// result waits for a full output register. If the receiver stalls, the
// response holds unchanged.
// cfg_we writes symbol_count and drops the built tree. Reset restores
// symbol_count to 64, marks no tree built and empties the output register;
// no clearing pass runs.
module huffman_tree_code_builder_core
	import htcb_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_item_t        req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_item_t        rsp_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	htcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req_data.cmd),
		.req_last  (req_data.last),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	htcb_dpath #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

`ifndef SYNTHESIS
	// No code without a built tree
	a_no_code_unready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.ready_res |-> rsp_data.code_length == '0)
		else $error("code reported without a built tree");

	// Ones plus zeros make up the code length
	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ($countones(rsp_data.code_bits) + int'(rsp_data.zero_count)) ==
			int'(rsp_data.code_length))
		else $error("code bit counts disagree with code length");

	// Nothing above the code length
	a_code_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.code_bits >> rsp_data.code_length) == '0)
		else $error("code bits set above code length");
`endif

endmodule

FILE: rtl/core/htcb_dpath.sv
`timescale 1ns / 1ps
module htcb_dpath
	import htcb_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_item_t        req_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output rsp_item_t        rsp_data
);

	localparam int NODE_DEPTH = 2 * MAX_SYMBOLS - 2;
	localparam int NA_W = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
	localparam int NI_W = $clog2(2 * MAX_SYMBOLS - 1);
	localparam int HS_W = $clog2(MAX_SYMBOLS + 1);
	localparam int HA_W = $clog2(MAX_SYMBOLS);
	localparam int NW   = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
	localparam int WM_W = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
	localparam logic [WIN_W-1:0] WMASK = {WIN_W{1'b1}} >> (WIN_W - WM_W);

	// Storage
	logic [NW-1:0]   wt_mem   [NODE_DEPTH];
	logic [NI_W:0]   pl_mem   [NODE_DEPTH];
	logic [NI_W-1:0] heap_mem [MAX_SYMBOLS];

	// Control registers
	logic [CFG_W-1:0] sc_q;
	logic             tree_ready_q;
	logic [HS_W-1:0]  cnt_q;
	logic [HS_W-1:0]  hsize_q;
	logic [NI_W-1:0]  next_q;
	logic             final_q;
	logic             v_s1;
	logic             v_s2;
	logic             best_valid_q;
	logic             rsp_valid_q;

	// Payload registers
	logic [HA_W-1:0]   pos_s1;
	logic [HA_W-1:0]   pos_s2;
	logic [NI_W-1:0]   node_s2;
	logic [NI_W-1:0]   heap_rd_q;
	logic [NW-1:0]     wt_rd_q;
	logic [NI_W:0]     pl_rd_q;
	logic [HA_W-1:0]   best_pos_q;
	logic [NI_W-1:0]   best_node_q;
	logic [NW-1:0]     best_w_q;
	logic [NI_W-1:0]   last_node_q;
	logic [NI_W-1:0]   a_node_q;
	logic [NW-1:0]     a_w_q;
	logic [NI_W-1:0]   b_node_q;
	logic [NW-1:0]     b_w_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  zeros_q;
	logic [CODE_W-1:0] code_q;
	rsp_item_t         rsp_q;

	// Combinational
	logic [HS_W-1:0] n;
	logic [NI_W-1:0] root;
	logic            sym_ok;
	logic [NI_W-1:0] sym_ni;
	logic [NW-1:0]   wload;
	logic [NI_W-1:0] parent_val;
	logic            scan_issue;
	logic            lighter;
	logic            walk_label;
	logic [NI_W-1:0] walk_parent;

	logic            heap_we;
	logic [HA_W-1:0] heap_waddr;
	logic [NI_W-1:0] heap_wdata;
	logic            wt_we;
	logic [NA_W-1:0] wt_waddr;
	logic [NW-1:0]   wt_wdata;
	logic            pl_we;
	logic [NA_W-1:0] pl_waddr;
	logic [NI_W:0]   pl_wdata;
	logic [NA_W-1:0] pl_raddr;

	// Clamp the alphabet size and derive the root index
	always_comb begin
		if (sc_q < CFG_W'(2)) begin
			n = HS_W'(2);
		end else if (sc_q > CFG_W'(MAX_SYMBOLS)) begin
			n = HS_W'(MAX_SYMBOLS);
		end else begin
			n = HS_W'(sc_q);
		end
	end

	assign root        = NI_W'(n) + NI_W'(n) - NI_W'(2);
	assign sym_ok      = CFG_W'(req_data.symbol) < CFG_W'(n);
	assign sym_ni      = NI_W'(req_data.symbol);
	assign wload       = NW'(req_data.weight & WMASK);
	assign parent_val  = final_q ? root : next_q;
	assign scan_issue  = cmd.scan && (cnt_q < hsize_q);
	assign lighter     = (wt_rd_q < best_w_q) ||
		((wt_rd_q == best_w_q) && (node_s2 < best_node_q));
	assign walk_label  = pl_rd_q[NI_W];
	assign walk_parent = pl_rd_q[NI_W-1:0];

	// Status back to the controller
	always_comb begin
		sts.query_ok   = tree_ready_q && sym_ok;
		sts.init_last  = cnt_q == (n - HS_W'(1));
		sts.scan_done  = (cnt_q == hsize_q) && !v_s1 && !v_s2;
		sts.final_pair = final_q;
		sts.walk_more  = (len_q < LEN_W'(WALK_MAX - 1)) && (walk_parent != root) &&
			(walk_parent < NI_W'(NODE_DEPTH));
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	// Select heap writes: seed, removal by swap with the tail, insert
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = cnt_q[HA_W-1:0];
		heap_wdata = NI_W'(cnt_q);
		if (cmd.init_wr) begin
			heap_we = 1'b1;
		end else if (cmd.take_a || cmd.take_b) begin
			heap_we    = 1'b1;
			heap_waddr = best_pos_q;
			heap_wdata = last_node_q;
		end else if (cmd.link_a && !final_q) begin
			heap_we    = 1'b1;
			heap_waddr = hsize_q[HA_W-1:0];
			heap_wdata = next_q;
		end
	end

	// Select weight writes: leaf load or merged parent
	always_comb begin
		wt_we    = 1'b0;
		wt_waddr = sym_ni[NA_W-1:0];
		wt_wdata = wload;
		if (cmd.load_wr && sym_ok) begin
			wt_we = 1'b1;
		end else if (cmd.link_a && !final_q) begin
			wt_we    = 1'b1;
			wt_waddr = next_q[NA_W-1:0];
			wt_wdata = a_w_q + b_w_q;
		end
	end

	// Select parent link writes
	always_comb begin
		pl_we    = cmd.link_a || cmd.link_b;
		pl_waddr = cmd.link_b ? b_node_q[NA_W-1:0] : a_node_q[NA_W-1:0];
		pl_wdata = {cmd.link_b, parent_val};
	end

	assign pl_raddr = cmd.query_start ? sym_ni[NA_W-1:0] : walk_parent[NA_W-1:0];

	// Memories with registered reads
	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
		heap_rd_q <= heap_mem[cnt_q[HA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_waddr] <= wt_wdata;
		end
		wt_rd_q <= wt_mem[heap_rd_q[NA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_waddr] <= pl_wdata;
		end
		pl_rd_q <= pl_mem[pl_raddr];
	end

	// Configuration, counters and scan valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q         <= CFG_RESET;
			tree_ready_q <= 1'b0;
			cnt_q        <= '0;
			hsize_q      <= '0;
			next_q       <= '0;
			final_q      <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			best_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				sc_q         <= cfg_wdata;
				tree_ready_q <= 1'b0;
			end else if (cmd.tree_set) begin
				tree_ready_q <= 1'b1;
			end
			if (cmd.build_start || cmd.scan_clr) begin
				cnt_q <= '0;
			end else if (cmd.init_wr || scan_issue) begin
				cnt_q <= cnt_q + HS_W'(1);
			end
			if (cmd.init_wr) begin
				hsize_q <= n;
				next_q  <= NI_W'(n);
			end else if (cmd.take_a || cmd.take_b) begin
				hsize_q <= hsize_q - HS_W'(1);
			end else if (cmd.link_a && !final_q) begin
				hsize_q <= hsize_q + HS_W'(1);
			end else if (cmd.link_b && !final_q) begin
				next_q <= next_q + NI_W'(1);
			end
			if (cmd.pair_start) begin
				final_q <= hsize_q <= HS_W'(2);
			end
			if (cmd.scan_clr) begin
				v_s1         <= 1'b0;
				v_s2         <= 1'b0;
				best_valid_q <= 1'b0;
			end else begin
				v_s1 <= scan_issue;
				v_s2 <= v_s1;
				if (v_s2) begin
					best_valid_q <= 1'b1;
				end
			end
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Scan pipeline payload, picked nodes, code walk and result register
	always_ff @(posedge clk) begin
		pos_s1  <= cnt_q[HA_W-1:0];
		pos_s2  <= pos_s1;
		node_s2 <= heap_rd_q;
		if (v_s2) begin
			last_node_q <= node_s2;
			if (!best_valid_q || lighter) begin
				best_pos_q  <= pos_s2;
				best_node_q <= node_s2;
				best_w_q    <= wt_rd_q;
			end
		end
		if (cmd.take_a) begin
			a_node_q <= best_node_q;
			a_w_q    <= best_w_q;
		end
		if (cmd.take_b) begin
			b_node_q <= best_node_q;
			b_w_q    <= best_w_q;
		end
		if (cmd.query_start) begin
			len_q   <= '0;
			zeros_q <= '0;
			code_q  <= '0;
		end else if (cmd.walk_step) begin
			len_q <= len_q + LEN_W'(1);
			if (walk_label) begin
				code_q <= code_q | (CODE_W'(1) << len_q);
			end else begin
				zeros_q <= zeros_q + LEN_W'(1);
			end
		end
		if (cmd.res_load) begin
			rsp_q.ready_res   <= tree_ready_q;
			rsp_q.code_length <= len_q;
			rsp_q.zero_count  <= zeros_q;
			rsp_q.code_bits   <= code_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

FILE: rtl/core/htcb_ctrl.sv
`timescale 1ns / 1ps
module htcb_ctrl
	import htcb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_cmd,
	input  logic    req_last,
	output logic    req_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nx;
	logic        accept;

	assign accept = req_valid && (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_cmd == CMD_QUERY) begin
						state_nx = sts.query_ok ? ST_WALK : ST_RESULT;
					end else if (req_last) begin
						state_nx = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				if (sts.init_last) begin
					state_nx = ST_PREP_A;
				end
			end
			ST_PREP_A: state_nx = ST_SCAN_A;
			ST_SCAN_A: begin
				if (sts.scan_done) begin
					state_nx = ST_TAKE_A;
				end
			end
			ST_TAKE_A: state_nx = ST_PREP_B;
			ST_PREP_B: state_nx = ST_SCAN_B;
			ST_SCAN_B: begin
				if (sts.scan_done) begin
					state_nx = ST_TAKE_B;
				end
			end
			ST_TAKE_B: state_nx = ST_LINK_A;
			ST_LINK_A: state_nx = ST_LINK_B;
			ST_LINK_B: state_nx = sts.final_pair ? ST_IDLE : ST_PREP_A;
			ST_WALK: begin
				if (!sts.walk_more) begin
					state_nx = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_cmd == CMD_QUERY) begin
						cmd.query_start = 1'b1;
					end else begin
						cmd.load_wr     = 1'b1;
						cmd.build_start = req_last;
					end
				end
			end
			ST_INIT: cmd.init_wr = 1'b1;
			ST_PREP_A: begin
				cmd.pair_start = 1'b1;
				cmd.scan_clr   = 1'b1;
			end
			ST_SCAN_A: cmd.scan = 1'b1;
			ST_TAKE_A: cmd.take_a = 1'b1;
			ST_PREP_B: cmd.scan_clr = 1'b1;
			ST_SCAN_B: cmd.scan = 1'b1;
			ST_TAKE_B: cmd.take_b = 1'b1;
			ST_LINK_A: cmd.link_a = 1'b1;
			ST_LINK_B: begin
				cmd.link_b   = 1'b1;
				cmd.tree_set = sts.final_pair;
			end
			ST_WALK: cmd.walk_step = 1'b1;
			ST_RESULT: cmd.res_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: dv/huffman_code_checker.sv
`timescale 1ns / 1ps
module huffman_code_checker
	import htcb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_item_t        req_data,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_item_t        rsp_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               codes_pending,
	output int               queries_seen
);

	localparam int NODES = 2 * MAX_SYMBOLS_DEF - 2;

	logic [63:0] wt [NODES];
	logic [6:0]  parent [NODES];
	logic        label [NODES];
	logic [6:0]  live [MAX_SYMBOLS_DEF];
	int          live_n;
	logic        built;
	logic [6:0]  alphabet_reg;
	rsp_item_t   expected_codes[$];

	function automatic int alphabet_size();
		int n;
		n = alphabet_reg;
		if (n < 2) n = 2;
		if (n > MAX_SYMBOLS_DEF) n = MAX_SYMBOLS_DEF;
		return n;
	endfunction

	// Pop the lightest live node, ties go to lower node index
	function automatic int pop_lightest();
		int best;
		int nd;
		best = 0;
		for (int i = 1; i < live_n; i++) begin
			if (wt[live[i]] < wt[live[best]] ||
				(wt[live[i]] == wt[live[best]] && live[i] < live[best]))
				best = i;
		end
		nd = live[best];
		live_n--;
		live[best] = live[live_n];
		return nd;
	endfunction

	task automatic build_code_tree();
		int n;
		int nxt;
		int a;
		int b;
		n = alphabet_size();
		nxt = n;
		for (int i = 0; i < n; i++) live[i] = 7'(i);
		live_n = n;
		while (live_n > 2) begin
			a = pop_lightest();
			b = pop_lightest();
			parent[a] = 7'(nxt); label[a] = 1'b0;
			parent[b] = 7'(nxt); label[b] = 1'b1;
			wt[nxt] = wt[a] + wt[b];
			live[live_n] = 7'(nxt);
			live_n++;
			nxt++;
		end
		a = pop_lightest();
		b = pop_lightest();
		parent[a] = 7'(2 * n - 2); label[a] = 1'b0;
		parent[b] = 7'(2 * n - 2); label[b] = 1'b1;
		built = 1'b1;
	endtask

	function automatic rsp_item_t lookup_code(int sym);
		rsp_item_t r;
		int nd;
		int root;
		r = '0;
		r.ready_res = built;
		root = 2 * alphabet_size() - 2;
		if (built && sym < alphabet_size()) begin
			nd = sym;
			for (int s = 0; s < 63 && nd != root && nd < NODES; s++) begin
				if (label[nd]) r.code_bits[r.code_length] = 1'b1;
				else r.zero_count++;
				r.code_length++;
				nd = parent[nd];
			end
		end
		return r;
	endfunction

	assign codes_pending = expected_codes.size();

	// Track config, predict on request transactions, compare on responses
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t exp_r;
		if (!arst_n) begin
			alphabet_reg = CFG_RESET;
			built = 1'b0;
			fail_count <= 0;
			queries_seen <= 0;
			expected_codes.delete();
		end else begin
			if (cfg_we) begin
				alphabet_reg = cfg_wdata;
				built = 1'b0;
			end
			if (req_valid && !req_stall) begin
				if (req_data.cmd == CMD_LOAD) begin
					if (req_data.symbol < alphabet_size())
						wt[req_data.symbol] = 64'(req_data.weight);
					if (req_data.last) build_code_tree();
				end else begin
					expected_codes.push_back(lookup_code(req_data.symbol));
				end
			end
			if (rsp_valid && !rsp_stall) begin
				queries_seen <= queries_seen + 1;
				if (expected_codes.size() == 0) begin
					if (fail_count < 10) $display("ERROR: unexpected response %h", rsp_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_codes.pop_front();
					if (exp_r !== rsp_data) begin
						if (fail_count < 10)
							$display("ERROR: code mismatch exp rdy%0d len%0d z%0d %h got rdy%0d len%0d z%0d %h",
								exp_r.ready_res, exp_r.code_length, exp_r.zero_count,
								exp_r.code_bits, rsp_data.ready_res, rsp_data.code_length,
								rsp_data.zero_count, rsp_data.code_bits);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import htcb_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_item_t        req_data;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_item_t        rsp_data;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	int               fail_count;
	int               codes_pending;
	int               queries_seen;
	int               idle_cycles;
	bit               steady_mode;
	int               alphabet;
	int               loads_sent;
	int               builds_run;
	int               weight_style;

	huffman_tree_code_builder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	huffman_code_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_data     (req_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_data     (rsp_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.codes_pending(codes_pending),
		.queries_seen (queries_seen)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Receiver stall: random, except during the steady stretch
	always @(posedge clk) begin
		rsp_stall <= steady_mode ? 1'b0 : ($urandom_range(99) < 31);
	end

	// Watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 40000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Send one request transaction, with a random gap first; valid stays up after
	task automatic send_req(logic cmd, int sym, logic [23:0] w, logic lst);
		while (!steady_mode && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= '{cmd: cmd, symbol: 6'(sym), weight: w, last: lst};
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_weight();
		case (weight_style)
			0: return 24'($urandom);
			1: return 24'($urandom_range(3));
			2: return 24'hFFFFFF - 24'($urandom_range(3));
			default: return 24'(1) << $urandom_range(23);
		endcase
	endfunction

	// Load a full weight set ending in last, which starts a build
	task automatic load_set();
		for (int s = 0; s < alphabet; s++) begin
			send_req(CMD_LOAD, s, pick_weight(), s == alphabet - 1);
			loads_sent++;
		end
		builds_run++;
	endtask

	// Drain responses, wait out the build, then write the register
	task automatic set_alphabet(int value);
		req_valid <= 1'b0;
		while (codes_pending != 0) @(posedge clk);
		repeat (6000) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= 7'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		alphabet = value < 2 ? 2 : (value > 64 ? 64 : value);
	endtask

	initial begin
		int sizes[6];
		sizes = '{64, 2, 0, 127, 5, 17};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		steady_mode = 1'b0;
		alphabet = 64;
		loads_sent = 0;
		builds_run = 0;
		weight_style = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: query before build, extreme weights, out-of-range symbols
		send_req(CMD_QUERY, 0, '0, 1'b0);
		send_req(CMD_QUERY, 63, '1, 1'b1);
		weight_style = 2;
		load_set();
		send_req(CMD_QUERY, 0, '0, 1'b0);
		send_req(CMD_QUERY, 63, '0, 1'b0);
		send_req(CMD_LOAD, 5, '0, 1'b0);
		send_req(CMD_QUERY, 5, '0, 1'b0);
		set_alphabet(2);
		send_req(CMD_LOAD, 0, 24'hFFFFFF, 1'b0);
		send_req(CMD_LOAD, 1, 24'h0, 1'b0);
		send_req(CMD_LOAD, 40, 24'h123456, 1'b1);
		send_req(CMD_QUERY, 0, '0, 1'b0);
		send_req(CMD_QUERY, 1, '0, 1'b0);
		send_req(CMD_QUERY, 2, '0, 1'b0);

		// Random phases across alphabet sizes and weight shapes
		for (int ph = 0; ph < 24; ph++) begin
			if (ph % 4 == 0) set_alphabet(sizes[(ph / 4) % 6]);
			steady_mode = (ph == 10);
			send_req(CMD_QUERY, $urandom_range(63), 24'($urandom), 1'($urandom));
			weight_style = $urandom_range(3);
			if (alphabet <= 20 || ph % 3 == 0) load_set();
			for (int q = 0; q < 12; q++) begin
				if ($urandom_range(9) == 0)
					send_req(CMD_LOAD, $urandom_range(63), 24'($urandom), 1'b0);
				else if ($urandom_range(3) == 0)
					send_req(CMD_QUERY, $urandom_range(63), 24'($urandom), 1'($urandom));
				else
					send_req(CMD_QUERY, $urandom_range(alphabet - 1), 24'($urandom), 1'b0);
			end
			// Hold the sender until every response has come
			if (ph == 6) begin
				req_valid <= 1'b0;
				while (codes_pending != 0) @(posedge clk);
			end
		end
		steady_mode = 1'b0;

		req_valid <= 1'b0;
		while (codes_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d tree builds from %0d weight loads, %0d code lookups checked",
			builds_run, loads_sent, queries_seen);
		$display("Alphabet sizes 2 through 64 including saturated register writes");
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/htcb_pkg.sv
rtl/core/htcb_dpath.sv
rtl/core/htcb_ctrl.sv
rtl/core/huffman_tree_code_builder_core.sv
dv/huffman_code_checker.sv
dv/testbench.sv
